[hdl/tss_pkg.sv]
package tss_pkg;

  localparam int COL_W  = 6;
  localparam int STOP_W = 7;
  localparam int TAB_W  = 6;

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TILDE = 8'h7E;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_BELL  = 8'h07;

  localparam logic [TAB_W-1:0] TAB_RESET = 6'd8;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SPACE,
    ST_CHAR,
    ST_RECALC
  } state_t;

  typedef struct packed {
    logic take_in;
    logic take_cfg;
    logic space_step;
    logic char_done;
    logic recalc_step;
    logic show_space;
  } dp_cmd_t;

  typedef struct packed {
    logic in_print;
    logic in_pass;
    logic owed;
    logic space_last;
    logic recalc_done;
  } dp_status_t;

  function automatic logic [TAB_W-1:0] eff_tab(input logic [TAB_W-1:0] w);
    logic [TAB_W-1:0] r;
    r = w;
    if (w == '0) begin
      r = 6'd1;
    end else if (w > 6'd32) begin
      r = 6'd32;
    end
    return r;
  endfunction

  function automatic logic is_print(input logic [7:0] c);
    return (c > CH_SPACE) && (c <= CH_TILDE);
  endfunction

endpackage

[hdl/tss_ctrl.sv]
module tss_ctrl import tss_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  output logic       out_valid,
  input  logic       out_ready,
  input  dp_status_t status,
  output dp_cmd_t    cmd
);

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (cfg_valid) begin
          state_nxt = ST_RECALC;
        end else if (in_valid) begin
          if (status.in_print && status.owed) begin
            state_nxt = ST_SPACE;
          end else if (status.in_print || status.in_pass) begin
            state_nxt = ST_CHAR;
          end
        end
      end
      ST_SPACE: begin
        if (out_ready && status.space_last) begin
          state_nxt = ST_CHAR;
        end
      end
      ST_CHAR: begin
        if (out_ready) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_RECALC: begin
        if (status.recalc_done) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd       = '0;
    in_ready  = 1'b0;
    cfg_ready = 1'b0;
    out_valid = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        cfg_ready    = 1'b1;
        in_ready     = !cfg_valid;
        cmd.take_cfg = cfg_valid;
        cmd.take_in  = in_valid && !cfg_valid;
      end
      ST_SPACE: begin
        out_valid      = 1'b1;
        cmd.show_space = 1'b1;
        cmd.space_step = out_ready;
      end
      ST_CHAR: begin
        out_valid     = 1'b1;
        cmd.char_done = out_ready;
      end
      ST_RECALC: begin
        cmd.recalc_step = !status.recalc_done;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

[hdl/tss_datapath.sv]
module tss_datapath import tss_pkg::*; #(
  parameter int MAX_COLUMN = 63
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic [7:0]       in_char_in,
  input  logic [TAB_W-1:0] cfg_data,
  input  dp_cmd_t          cmd,
  output dp_status_t       status,
  output logic [7:0]       out_char_out,
  output logic             out_last_of_run
);

  localparam logic [COL_W-1:0]  MAX_C = COL_W'(MAX_COLUMN);
  localparam logic [STOP_W-1:0] MAX_S = STOP_W'(MAX_COLUMN);

  logic [TAB_W-1:0]  tab_r;
  logic [COL_W-1:0]  column_r;
  logic [COL_W-1:0]  lpc_r;
  logic [COL_W-1:0]  p_r;
  logic [STOP_W-1:0] stop_r;
  logic [7:0]        char_r;

  logic [TAB_W-1:0]  w;
  logic [STOP_W-1:0] stop_adv;
  logic [STOP_W-1:0] col_inc;
  logic [COL_W-1:0]  col_step;
  logic              at_max;

  assign w        = eff_tab(tab_r);
  assign stop_adv = stop_r + {1'b0, w};
  assign col_inc  = {1'b0, column_r} + 7'd1;
  assign at_max   = (column_r >= MAX_C);
  assign col_step = at_max ? MAX_C : col_inc[COL_W-1:0];

  assign status.in_print    = is_print(in_char_in);
  assign status.in_pass     = (in_char_in == CH_LF) || (in_char_in == CH_CR) ||
                              (in_char_in == CH_BELL);
  assign status.owed        = (lpc_r < column_r);
  assign status.space_last  = ({1'b0, p_r} + 7'd1) == {1'b0, column_r};
  assign status.recalc_done = (stop_r > {1'b0, column_r});

  assign out_char_out    = cmd.show_space ? CH_SPACE : char_r;
  assign out_last_of_run = !cmd.show_space;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tab_r    <= TAB_RESET;
      column_r <= '0;
      lpc_r    <= '0;
      stop_r   <= {1'b0, eff_tab(TAB_RESET)};
    end else begin
      if (cmd.take_cfg) begin
        tab_r  <= cfg_data;
        stop_r <= '0;
      end
      if (cmd.recalc_step) begin
        stop_r <= stop_adv;
      end
      if (cmd.take_in) begin
        if (in_char_in == CH_SPACE) begin
          column_r <= col_step;
          if (!at_max && col_inc == stop_r) begin
            stop_r <= stop_adv;
          end
        end else if (in_char_in == CH_TAB) begin
          if (stop_r <= MAX_S) begin
            column_r <= stop_r[COL_W-1:0];
            stop_r   <= stop_adv;
          end else begin
            column_r <= MAX_C;
          end
        end
      end
      if (cmd.char_done) begin
        if (is_print(char_r)) begin
          column_r <= col_step;
          lpc_r    <= col_step;
          if (!at_max && col_inc == stop_r) begin
            stop_r <= stop_adv;
          end
        end else if (char_r == CH_LF || char_r == CH_CR) begin
          column_r <= '0;
          lpc_r    <= '0;
          stop_r   <= {1'b0, w};
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take_in) begin
      char_r <= in_char_in;
      p_r    <= lpc_r;
    end else if (cmd.space_step) begin
      p_r <= p_r + 6'd1;
    end
  end

endmodule

[hdl/trailing_space_suppressor.sv]
// Trailing-space suppressor: one character per input transaction. Spaces and
// tabs only move the column; owed whitespace goes out as spaces just before the
// next printing character, so line-end whitespace is never sent. CR, LF and
// bell pass through; other bytes are dropped. A printing character goes out as
// the owed spaces and then the character; CR, LF and bell go out alone; space,
// tab and dropped bytes produce no output. Each result is held until out_ready.
// The next tab stop is kept in a register; after a tab_width write a recompute
// pass, which steps the stop up by the tab width until it passes the column,
// runs before input is accepted again.
module trailing_space_suppressor import tss_pkg::*; #(
  parameter int MAX_COLUMN = 63
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_char_in,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [5:0] cfg_tab_width,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_char_out,
  output logic       out_last_of_run
);

  dp_cmd_t    cmd;
  dp_status_t status;

  tss_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  tss_datapath #(
    .MAX_COLUMN (MAX_COLUMN)
  ) u_datapath (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_char_in      (in_char_in),
    .cfg_data        (cfg_tab_width),
    .cmd             (cmd),
    .status          (status),
    .out_char_out    (out_char_out),
    .out_last_of_run (out_last_of_run)
  );

  a_last_not_space: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last_of_run |-> out_char_out != CH_SPACE)
    else $error("final result of a transaction is a space");

  a_fill_is_space: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last_of_run |-> out_char_out == CH_SPACE)
    else $error("non-final result is not a space");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> !out_valid)
    else $error("input taken while results are pending");

  a_cfg_blocks_in: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_valid && cfg_ready |=> !in_ready)
    else $error("input taken right after a tab width write");

endmodule

[tb/sv/tss_checker.sv]
`timescale 1ns / 1ps
module tss_checker import tss_pkg::*; #(
  parameter int MAX_COLUMN = 63
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_ready,
  input  logic [7:0] in_char_in,
  input  logic       cfg_valid,
  input  logic       cfg_ready,
  input  logic [5:0] cfg_tab_width,
  input  logic       out_valid,
  input  logic       out_ready,
  input  logic [7:0] out_char_out,
  input  logic       out_last_of_run,
  output int         errors,
  output int         owed
);

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } console_beat_t;

  console_beat_t      console_q[$];
  logic [COL_W-1:0]   column;
  logic [COL_W-1:0]   printed_col;
  logic [TAB_W-1:0]   tab_setting;

  function automatic logic [COL_W-1:0] sat_column(input int v);
    return (v > MAX_COLUMN) ? COL_W'(MAX_COLUMN) : COL_W'(v);
  endfunction

  task automatic predict_char(input logic [7:0] c);
    int col;
    int w;
    col = column;
    if (c > CH_SPACE && c <= CH_TILDE) begin
      for (int p = printed_col; p < col; p++) begin
        console_q.push_back({CH_SPACE, 1'b0});
      end
      console_q.push_back({c, 1'b1});
      column = sat_column(col + 1);
      printed_col = column;
    end else if (c == CH_LF || c == CH_CR) begin
      console_q.push_back({c, 1'b1});
      column = '0;
      printed_col = '0;
    end else if (c == CH_TAB) begin
      w = tab_setting;
      if (w == 0) begin
        w = 1;
      end else if (w > 32) begin
        w = 32;
      end
      column = sat_column(((col + w) / w) * w);
    end else if (c == CH_SPACE) begin
      column = sat_column(col + 1);
    end else if (c == CH_BELL) begin
      console_q.push_back({c, 1'b1});
    end
  endtask

  always @(posedge clk) begin
    console_beat_t want;
    if (!rst_n) begin
      console_q.delete();
      column = '0;
      printed_col = '0;
      tab_setting = TAB_RESET;
    end else begin
      if (out_valid && out_ready) begin
        if (console_q.size() == 0) begin
          errors = errors + 1;
          if (errors <= 10) begin
            $display("%0t: unexpected transaction char=%h last=%b", $realtime,
                     out_char_out, out_last_of_run);
          end
        end else begin
          want = console_q.pop_front();
          if (want.ch !== out_char_out || want.last !== out_last_of_run) begin
            errors = errors + 1;
            if (errors <= 10) begin
              $display("%0t: mismatch expected char=%h last=%b, got char=%h last=%b",
                       $realtime, want.ch, want.last, out_char_out, out_last_of_run);
            end
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        tab_setting = cfg_tab_width;
      end
      if (in_valid && in_ready) begin
        predict_char(in_char_in);
      end
    end
    owed = console_q.size();
  end

endmodule

[tb/sv/tb.sv]
`timescale 1ns / 1ps
module tb;
  import tss_pkg::*;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] in_char_in = 8'h00;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [5:0] cfg_tab_width = 6'd0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [7:0] out_char_out;
  logic       out_last_of_run;
  logic       hold_req = 1'b0;
  int         hold_cnt = 0;
  int         in_idle = 23;
  int         out_idle = 63;
  int         fail_cnt;
  int         owed_cnt;

  trailing_space_suppressor dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_char_in      (in_char_in),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_tab_width   (cfg_tab_width),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_char_out    (out_char_out),
    .out_last_of_run (out_last_of_run)
  );

  tss_checker checker_i (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_char_in      (in_char_in),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_tab_width   (cfg_tab_width),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_char_out    (out_char_out),
    .out_last_of_run (out_last_of_run),
    .errors          (fail_cnt),
    .owed            (owed_cnt)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (hold_cnt != 0) begin
      hold_cnt <= hold_cnt - 1;
    end else if (hold_req) begin
      hold_cnt <= 200;
    end
    out_ready <= (hold_cnt == 0) && !hold_req && ($urandom_range(99) >= out_idle);
  end

  initial begin
    #2_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  task automatic send_char(input logic [7:0] c);
    while ($urandom_range(99) < in_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_char_in <= c;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic write_tab(input logic [5:0] w);
    cfg_valid <= 1'b1;
    cfg_tab_width <= w;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  task automatic drain_console();
    in_valid <= 1'b0;
    @(posedge clk);
    while (owed_cnt != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  function automatic logic [7:0] text_char();
    int r;
    r = $urandom_range(99);
    if (r < 50) begin
      return 8'($urandom_range(8'h7E, 8'h21));
    end else if (r < 70) begin
      return CH_SPACE;
    end else if (r < 80) begin
      return CH_TAB;
    end else if (r < 84) begin
      return CH_LF;
    end else if (r < 87) begin
      return CH_CR;
    end else if (r < 90) begin
      return CH_BELL;
    end
    return 8'($urandom_range(255));
  endfunction

  initial begin
    logic [5:0] widths [9];
    int         n;
    widths[0] = 6'd1;
    widths[1] = 6'd0;
    widths[2] = 6'd32;
    widths[3] = 6'd63;
    widths[4] = 6'd33;
    widths[5] = 6'd3;
    widths[6] = 6'd5;
    widths[7] = 6'd8;
    widths[8] = 6'($urandom_range(63));
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_char(8'h21);
    send_char(CH_TILDE);
    send_char(CH_SPACE);
    send_char(CH_TAB);
    send_char(8'h41);
    send_char(CH_SPACE);
    send_char(CH_SPACE);
    send_char(CH_CR);
    send_char(CH_TAB);
    send_char(CH_LF);
    send_char(CH_BELL);
    send_char(8'h00);
    send_char(8'h7F);
    send_char(8'h80);
    send_char(8'hFF);
    send_char(8'h1F);
    repeat (8) send_char(CH_TAB);
    send_char(8'h5A);
    send_char(8'h7A);
    send_char(CH_SPACE);
    send_char(8'h30);
    send_char(CH_LF);

    for (int p = 0; p < 9; p++) begin
      if (p == 3) begin
        in_idle = 63;
        out_idle = 23;
      end
      if (p == 6) begin
        in_idle = 0;
        out_idle = 0;
      end
      drain_console();
      write_tab(widths[p]);
      if (p == 4) begin
        hold_req <= 1'b1;
        @(posedge clk);
        hold_req <= 1'b0;
      end
      repeat (50) send_char(text_char());
    end

    in_valid <= 1'b0;
    @(posedge clk);
    n = 0;
    while (owed_cnt != 0 && n < 50000) begin
      @(posedge clk);
      n++;
    end
    repeat (70) @(posedge clk);
    if (fail_cnt == 0 && owed_cnt == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

[trailing_space_suppressor.f]
hdl/tss_pkg.sv
hdl/tss_ctrl.sv
hdl/tss_datapath.sv
hdl/trailing_space_suppressor.sv
tb/sv/tss_checker.sv
tb/sv/tb.sv
